>>> src/ffha_pkg.sv
// shared types, constants and header helpers for the first-fit heap allocator
package ffha_pkg;

  localparam int ARENA_BYTES  = 16384;
  localparam int HEADER_BYTES = 16;
  localparam int OFF_W        = $clog2(ARENA_BYTES);
  localparam int SZ_W         = 14;
  localparam int SUM_W        = OFF_W + 2;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_SWEEP = 2'd3
  } req_t;

  typedef struct packed {
    logic            mark;
    logic            last;
    logic            free;
    logic [SZ_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef struct packed {
    logic             at_end;
    logic [OFF_W-1:0] nxt;
  } succ_t;

  function automatic succ_t succ_of(logic [OFF_W-1:0] off, hdr_t h);
    logic [SUM_W-1:0] sum;
    succ_t            s;
    sum = SUM_W'(off) + SUM_W'(h.size) + SUM_W'(HEADER_BYTES);
    s.at_end = h.last || (sum >= SUM_W'(ARENA_BYTES));
    s.nxt    = sum[OFF_W-1:0];
    return s;
  endfunction

endpackage

>>> src/ffha_ram.sv
// generic single-port-write ram with registered read
module ffha_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/first_fit_heap_allocator.sv
// first-fit heap allocator: header chain sequencer over a header ram
// a request walks the header chain, reading each header visited, with a merge or split step
//   where needed and a registered output; a request that is ignored at once skips the walk
// throughput: one request at a time, busy stays high while the chain walk is under way
// the walk is set by one header ram read per block on the chain
// reset: synchronous active-low rst_n; root header set free and last, no clearing pass
// results are strobed on out_valid for one cycle; the receiver cannot stall
module first_fit_heap_allocator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [ffha_pkg::SZ_W-1:0]  in_req_size,
  input  logic [ffha_pkg::OFF_W-1:0] in_req_addr,
  output logic                     out_valid,
  output logic [ffha_pkg::OFF_W-1:0] out_result_addr,
  output logic                     out_result_ok
);
  import ffha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_READN = 7'b0001000,
    S_MERGE = 7'b0010000,
    S_SPLIT = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] nxt_r, nxt_nxt;
  hdr_t             hd_r, hd_nxt;
  hdr_t             root_r;
  logic             rd_root_r, rd_root_nxt;
  req_t             type_r;
  logic [SZ_W-1:0]  size_r;
  logic [OFF_W-1:0] addr_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] res_addr_r, res_addr_nxt;
  logic             res_ok_r, res_ok_nxt;

  logic             wr_en;
  logic [OFF_W-1:0] wr_addr;
  hdr_t             wr_data;
  logic [OFF_W-1:0] rd_addr;
  logic [HDR_W-1:0] ram_q;
  hdr_t             hdr_in;
  succ_t            sc;
  succ_t            sc_n;
  logic [SUM_W-1:0] split_n;
  logic [OFF_W-1:0] target;
  logic             accept;
  hdr_t             merged;

  ffha_ram #(.W(HDR_W), .D(ARENA_BYTES)) u_ram (
    .clk   (clk),
    .we    (wr_en && (wr_addr != '0)),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign hdr_in  = rd_root_r ? root_r : hdr_t'(ram_q);
  assign sc      = succ_of(off_r, hdr_in);
  assign sc_n    = succ_of(nxt_r, hdr_in);
  assign split_n = SUM_W'(off_r) + SUM_W'(size_r) + SUM_W'(HEADER_BYTES);
  assign target  = addr_r - OFF_W'(HEADER_BYTES);
  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    merged      = hd_r;
    merged.free = 1'b1;
    if (hdr_in.free) begin
      merged.last = hdr_in.last;
      merged.size = hd_r.size + hdr_in.size + SZ_W'(HEADER_BYTES);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    off_nxt       = off_r;
    nxt_nxt       = nxt_r;
    hd_nxt        = hd_r;
    rd_root_nxt   = rd_root_r;
    out_valid_nxt = 1'b0;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    wr_en         = 1'b0;
    wr_addr       = off_r;
    wr_data       = hd_r;
    rd_addr       = off_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          off_nxt      = '0;
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b1;
          if ((req_t'(in_req_type) == REQ_FREE || req_t'(in_req_type) == REQ_MARK) &&
              in_req_addr < OFF_W'(HEADER_BYTES)) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        rd_addr     = off_r;
        rd_root_nxt = (off_r == '0);
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        hd_nxt = hdr_in;
        unique case (type_r)
          REQ_ALLOC: begin
            if (hdr_in.free && hdr_in.size > size_r) begin
              res_addr_nxt = off_r + OFF_W'(HEADER_BYTES);
              if ({1'b0, hdr_in.size} > {1'b0, size_r} + (SZ_W+1)'(HEADER_BYTES) &&
                  split_n < SUM_W'(ARENA_BYTES)) begin
                wr_en        = 1'b1;
                wr_addr      = split_n[OFF_W-1:0];
                wr_data.mark = 1'b0;
                wr_data.last = hdr_in.last;
                wr_data.free = 1'b1;
                wr_data.size = hdr_in.size - size_r - SZ_W'(HEADER_BYTES);
                state_nxt    = S_SPLIT;
              end else begin
                wr_en         = 1'b1;
                wr_data       = hdr_in;
                wr_data.free  = 1'b0;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
            end else if (sc.at_end) begin
              res_ok_nxt    = 1'b0;
              res_addr_nxt  = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              off_nxt   = sc.nxt;
              state_nxt = S_READ;
            end
          end
          REQ_FREE, REQ_MARK: begin
            if (off_r == target) begin
              if (type_r == REQ_MARK) begin
                wr_en         = 1'b1;
                wr_data       = hdr_in;
                wr_data.mark  = 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                hd_nxt.free = 1'b1;
                if (sc.at_end) begin
                  wr_en         = 1'b1;
                  wr_data       = hdr_in;
                  wr_data.free  = 1'b1;
                  out_valid_nxt = 1'b1;
                  state_nxt     = S_IDLE;
                end else begin
                  nxt_nxt   = sc.nxt;
                  state_nxt = S_READN;
                end
              end
            end else if (off_r > target || sc.at_end) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              off_nxt   = sc.nxt;
              state_nxt = S_READ;
            end
          end
          REQ_SWEEP: begin
            if (!hdr_in.mark) begin
              hd_nxt.free = 1'b1;
              if (sc.at_end) begin
                wr_en         = 1'b1;
                wr_data       = hdr_in;
                wr_data.free  = 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                nxt_nxt   = sc.nxt;
                state_nxt = S_READN;
              end
            end else if (sc.at_end) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              off_nxt   = sc.nxt;
              state_nxt = S_READ;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_READN: begin
        rd_addr     = nxt_r;
        rd_root_nxt = 1'b0;
        state_nxt   = S_MERGE;
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_data = merged;
        // successor of the merged block equals that of the absorbed one
        if (type_r == REQ_SWEEP) begin
          if (hdr_in.free) begin
            if (sc_n.at_end) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              off_nxt   = sc_n.nxt;
              state_nxt = S_READ;
            end
          end else begin
            off_nxt   = nxt_r;
            state_nxt = S_READ;
          end
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SPLIT: begin
        wr_en         = 1'b1;
        wr_data.mark  = hd_r.mark;
        wr_data.last  = 1'b0;
        wr_data.free  = 1'b0;
        wr_data.size  = size_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_root_r   <= 1'b0;
      out_valid_r <= 1'b0;
      root_r      <= '{mark: 1'b0, last: 1'b1, free: 1'b1,
                       size: SZ_W'(ARENA_BYTES - HEADER_BYTES)};
    end else begin
      state_r     <= state_nxt;
      rd_root_r   <= rd_root_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en && wr_addr == '0) begin
        root_r <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    nxt_r      <= nxt_nxt;
    hd_r       <= hd_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    if (accept) begin
      type_r <= req_t'(in_req_type);
      size_r <= in_req_size;
      addr_r <= in_req_addr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = res_addr_r;
  assign out_result_ok   = res_ok_r;

endmodule
